[rtl/core/gcbs_pkg.sv]
// Package for the group column bit swap block: item and result layouts,
// kind and state codes, fixed field widths. No dependencies.
package gcbs_pkg;

  // Fixed field widths of the stream items
  localparam int ROW_IN_W  = 10;
  localparam int COL_W     = 6;
  localparam int GID_W     = 32;
  localparam int GSIZE_W   = 5;
  localparam int BITS_W    = 64;
  localparam int CNT_W     = 5;
  localparam int RC_W      = 11;
  localparam int GRP_W     = GID_W + GSIZE_W;
  localparam int KIND_W    = 2;

  localparam logic [RC_W-1:0] ROW_COUNT_RESET = 11'd1024;

  // Item kinds carried on s_tuser; the fourth code is unused
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_HEAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One input transaction, unpacked
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ROW_IN_W-1:0] target_row;
    logic [GID_W-1:0]    group_id;
    logic [GSIZE_W-1:0]  group_size;
    logic [BITS_W-1:0]   row_bits;
    logic [ROW_IN_W-1:0] clear_row;
    logic [COL_W-1:0]    clear_col;
    logic [ROW_IN_W-1:0] add_row;
    logic [COL_W-1:0]    add_col;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [BITS_W-1:0] read_bits;
    logic [CNT_W-1:0]  cleared_count;
    logic [CNT_W-1:0]  set_count;
    logic              bad_index;
  } result_t;

endpackage

[rtl/core/gcbs_ram.sv]
// Simple dual-port synchronous RAM, one write and one read port,
// read data registered. No dependencies.
module gcbs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/gcbs_ctrl.sv]
// Sequencer for the group column bit swap block: decodes a transaction,
// runs the remove and add window scans as read-modify-write over the row bits RAM.
// Depends on gcbs_pkg.
module gcbs_ctrl #(
  parameter int ROWS = 1024,
  parameter int COLS = 64,
  parameter int MAX_GROUP = 16,
  localparam int RA_W = $clog2(ROWS)
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [gcbs_pkg::RC_W-1:0]   cfg_wdata,
  // incoming item
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gcbs_pkg::item_t             item_in,
  // result hand-off to the output register
  input  logic                        out_free,
  output logic                        res_valid,
  output gcbs_pkg::result_t           res,
  // row bits memory
  output logic                        bits_we,
  output logic [RA_W-1:0]             bits_waddr,
  output logic [COLS-1:0]             bits_wdata,
  output logic                        bits_re,
  output logic [RA_W-1:0]             bits_raddr,
  input  logic [COLS-1:0]             bits_rdata,
  // group id / size memory
  output logic                        grp_we,
  output logic [RA_W-1:0]             grp_waddr,
  output logic [gcbs_pkg::GRP_W-1:0]  grp_wdata,
  output logic                        grp_re,
  output logic [RA_W-1:0]             grp_raddr,
  input  logic [gcbs_pkg::GRP_W-1:0]  grp_rdata
);

  import gcbs_pkg::*;

  localparam int N_W = $clog2(ROWS + 1);
  // window arithmetic: room for row + size - 1
  localparam int WW  = ((RA_W > 6) ? RA_W : 6) + 1;

  // registers
  state_t             state, state_next;
  logic [RC_W-1:0]    row_count;
  item_t              item, item_next;
  logic               pass, pass_next;
  logic [GID_W-1:0]   grp_id, grp_id_next;
  logic [CNT_W-1:0]   grp_s, grp_s_next;
  logic [WW-1:0]      hi, hi_next;
  logic [WW-1:0]      j, j_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               rd_pend, rd_pend_next;
  logic [RA_W-1:0]    rd_row, rd_row_next;
  logic               stop, stop_next;
  result_t            res_next;

  // combinational helpers
  logic [N_W-1:0]     n_use;
  logic [WW-1:0]      n_w;
  logic               trow_bad;
  logic               upd_bad;
  logic [ROW_IN_W-1:0] pass_row;
  logic [COL_W-1:0]   pass_col;
  logic [ROW_IN_W-1:0] next_head_row;
  logic [CNT_W-1:0]   s_raw;
  logic [CNT_W-1:0]   s_sat;
  logic [WW-1:0]      r_w;
  logic [WW-1:0]      s_w;
  logic [WW-1:0]      lo_calc;
  logic [WW-1:0]      hi_full;
  logic [WW-1:0]      hi_calc;
  logic [COLS-1:0]    col_bit;
  logic               match;
  logic [CNT_W-1:0]   cnt_inc;
  logic               stop_hit;
  logic               issue;
  logic [CNT_W-1:0]   pass_count;

  // effective row count and index checks
  assign n_use    = (32'(row_count) < ROWS) ? N_W'(row_count) : N_W'(ROWS);
  assign n_w      = WW'(n_use);
  assign trow_bad = 32'(item.target_row) >= 32'(n_use);
  assign upd_bad  = (32'(item.clear_row) >= 32'(n_use)) ||
                    (32'(item.add_row) >= 32'(n_use)) ||
                    (32'(item.clear_col) >= COLS) ||
                    (32'(item.add_col) >= COLS);

  // per-pass operands
  assign pass_row      = pass ? item.add_row : item.clear_row;
  assign pass_col      = pass ? item.add_col : item.clear_col;
  assign next_head_row = item.add_row;
  assign col_bit       = COLS'(1) << pass_col;

  // window from the head row's stored size, saturated
  assign s_raw   = grp_rdata[GRP_W-1:GID_W];
  assign s_sat   = (32'(s_raw) > MAX_GROUP) ? CNT_W'(MAX_GROUP) : s_raw;
  assign r_w     = WW'(pass_row);
  assign s_w     = WW'(s_sat);
  assign lo_calc = (r_w >= s_w - WW'(1)) ? r_w - (s_w - WW'(1)) : '0;
  assign hi_full = r_w + s_w - WW'(1);
  assign hi_calc = (hi_full > n_w - WW'(1)) ? n_w - WW'(1) : hi_full;

  // scan step: match on the row read last cycle
  assign match      = rd_pend && !stop && (grp_rdata[GID_W-1:0] == grp_id);
  assign cnt_inc    = cnt + CNT_W'(1);
  assign stop_hit   = stop || (match && (cnt_inc == grp_s));
  assign issue      = (j <= hi) && !stop_hit;
  assign pass_count = match ? cnt_inc : cnt;

  // state and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_count <= ROW_COUNT_RESET;
      rd_pend   <= 1'b0;
      stop      <= 1'b0;
      pass      <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
      stop    <= stop_next;
      pass    <= pass_next;
      if (cfg_we) begin
        row_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    grp_id <= grp_id_next;
    grp_s  <= grp_s_next;
    hi     <= hi_next;
    j      <= j_next;
    cnt    <= cnt_next;
    rd_row <= rd_row_next;
    res    <= res_next;
  end

  // next state, memory requests, result
  always_comb begin
    state_next   = state;
    item_next    = item;
    pass_next    = pass;
    grp_id_next  = grp_id;
    grp_s_next   = grp_s;
    hi_next      = hi;
    j_next       = j;
    cnt_next     = cnt;
    rd_pend_next = rd_pend;
    rd_row_next  = rd_row;
    stop_next    = stop;
    res_next     = res;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    bits_we      = 1'b0;
    bits_waddr   = '0;
    bits_wdata   = '0;
    bits_re      = 1'b0;
    bits_raddr   = '0;
    grp_we       = 1'b0;
    grp_waddr    = '0;
    grp_wdata    = '0;
    grp_re       = 1'b0;
    grp_raddr    = '0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next  = item_in;
          state_next = ST_EXEC;
        end
      end

      // decode and launch
      ST_EXEC: begin
        res_next   = '0;
        state_next = ST_DONE;
        unique case (item.kind)
          KIND_LOAD: begin
            if (trow_bad) begin
              res_next.bad_index = 1'b1;
            end else begin
              bits_we    = 1'b1;
              bits_waddr = RA_W'(item.target_row);
              bits_wdata = item.row_bits[COLS-1:0];
              grp_we     = 1'b1;
              grp_waddr  = RA_W'(item.target_row);
              grp_wdata  = {item.group_size, item.group_id};
            end
          end
          KIND_READ: begin
            if (trow_bad) begin
              res_next.bad_index = 1'b1;
            end else begin
              bits_re    = 1'b1;
              bits_raddr = RA_W'(item.target_row);
              state_next = ST_RDATA;
            end
          end
          KIND_UPDATE: begin
            if (upd_bad) begin
              res_next.bad_index = 1'b1;
            end else begin
              pass_next  = 1'b0;
              grp_re     = 1'b1;
              grp_raddr  = RA_W'(item.clear_row);
              state_next = ST_HEAD;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      ST_RDATA: begin
        res_next.read_bits = BITS_W'(bits_rdata);
        state_next         = ST_DONE;
      end

      // head row data is in: set up the window
      ST_HEAD: begin
        if (s_sat == '0) begin
          if (!pass) begin
            res_next.cleared_count = '0;
            pass_next  = 1'b1;
            grp_re     = 1'b1;
            grp_raddr  = RA_W'(next_head_row);
            state_next = ST_HEAD;
          end else begin
            res_next.set_count = '0;
            state_next = ST_DONE;
          end
        end else begin
          grp_id_next  = grp_rdata[GID_W-1:0];
          grp_s_next   = s_sat;
          j_next       = lo_calc;
          hi_next      = hi_calc;
          cnt_next     = '0;
          rd_pend_next = 1'b0;
          stop_next    = 1'b0;
          state_next   = ST_SCAN;
        end
      end

      // one row per cycle: write back last row, read the next
      ST_SCAN: begin
        if (match) begin
          bits_we    = 1'b1;
          bits_waddr = rd_row;
          bits_wdata = pass ? (bits_rdata | col_bit) : (bits_rdata & ~col_bit);
          cnt_next   = cnt_inc;
        end
        stop_next = stop_hit;
        if (issue) begin
          bits_re      = 1'b1;
          bits_raddr   = j[RA_W-1:0];
          grp_re       = 1'b1;
          grp_raddr    = j[RA_W-1:0];
          rd_row_next  = j[RA_W-1:0];
          j_next       = j + WW'(1);
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          if (!pass) begin
            res_next.cleared_count = pass_count;
            pass_next  = 1'b1;
            grp_re     = 1'b1;
            grp_raddr  = RA_W'(next_head_row);
            state_next = ST_HEAD;
          end else begin
            res_next.set_count = pass_count;
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/group_column_bit_swap.sv]
// Top level of the group column bit swap block: stream ports, output
// register, row bits RAM and group RAM. Depends on gcbs_pkg, gcbs_ram, gcbs_ctrl.
//
//  channel   signals                       moves
//  --------  ----------------------------  -------------------------------
//  cfg       cfg_we, cfg_wdata[10:0]       row_count write, no handshake
//  s_axis    s_tvalid/s_tready, s_tdata,   one load, update or read
//            s_tuser                       transaction
//  m_axis    m_tvalid/m_tready, m_tdata,   one result per transaction
//            m_tuser
//
// One transaction at a time. An update runs two passes, clear then add; each
// pass reads at most 2*MAX_GROUP-1 rows of its window, and a pass whose head
// row has size zero skips its scan. The bits RAM read-modify-write runs one
// row per cycle. rst is synchronous and clears the sequencer, the row count
// (to 1024) and the output valid. RAM contents are not cleared.
// A held result in the output register does not stop the next transaction
// being taken; only its completion waits for m_tready.
module group_column_bit_swap #(
  parameter int ROWS = 1024,
  parameter int COLS = 64,
  parameter int MAX_GROUP = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gcbs_pkg::RC_W-1:0]   cfg_wdata,   // row_count
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // target_row[9:0], group_id[41:10], group_size[46:42], row_bits[110:47],
  // clear_row[120:111], clear_col[126:121], add_row[136:127],
  // add_col[142:137], zero[143]
  input  logic [143:0]                s_tdata,
  input  logic [1:0]                  s_tuser,     // kind[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // read_bits[63:0], cleared_count[68:64], set_count[73:69], zero[79:74]
  output logic [79:0]                 m_tdata,
  output logic                        m_tuser      // bad_index
);

  import gcbs_pkg::*;

  localparam int RA_W = $clog2(ROWS);

  item_t            item_in;
  result_t          res;
  logic             res_valid;
  logic             out_free;
  result_t          out_res;

  logic             bits_we;
  logic [RA_W-1:0]  bits_waddr;
  logic [COLS-1:0]  bits_wdata;
  logic             bits_re;
  logic [RA_W-1:0]  bits_raddr;
  logic [COLS-1:0]  bits_rdata;
  logic             grp_we;
  logic [RA_W-1:0]  grp_waddr;
  logic [GRP_W-1:0] grp_wdata;
  logic             grp_re;
  logic [RA_W-1:0]  grp_raddr;
  logic [GRP_W-1:0] grp_rdata;

  // unpack the incoming transaction
  always_comb begin
    item_in.kind       = s_tuser;
    item_in.target_row = s_tdata[9:0];
    item_in.group_id   = s_tdata[41:10];
    item_in.group_size = s_tdata[46:42];
    item_in.row_bits   = s_tdata[110:47];
    item_in.clear_row  = s_tdata[120:111];
    item_in.clear_col  = s_tdata[126:121];
    item_in.add_row    = s_tdata[136:127];
    item_in.add_col    = s_tdata[142:137];
  end

  gcbs_ctrl #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item_in    (item_in),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .bits_we    (bits_we),
    .bits_waddr (bits_waddr),
    .bits_wdata (bits_wdata),
    .bits_re    (bits_re),
    .bits_raddr (bits_raddr),
    .bits_rdata (bits_rdata),
    .grp_we     (grp_we),
    .grp_waddr  (grp_waddr),
    .grp_wdata  (grp_wdata),
    .grp_re     (grp_re),
    .grp_raddr  (grp_raddr),
    .grp_rdata  (grp_rdata)
  );

  // row bits
  gcbs_ram #(
    .DEPTH (ROWS),
    .WIDTH (COLS)
  ) u_bits_ram (
    .clk   (clk),
    .we    (bits_we),
    .waddr (bits_waddr),
    .wdata (bits_wdata),
    .re    (bits_re),
    .raddr (bits_raddr),
    .rdata (bits_rdata)
  );

  // group size and id per row
  gcbs_ram #(
    .DEPTH (ROWS),
    .WIDTH (GRP_W)
  ) u_grp_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (grp_waddr),
    .wdata (grp_wdata),
    .re    (grp_re),
    .raddr (grp_raddr),
    .rdata (grp_rdata)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'b0, out_res.set_count, out_res.cleared_count, out_res.read_bits};
  assign m_tuser = out_res.bad_index;

endmodule
